[design/pquad_pkg.sv]
// ----------------------------------------------------------------------------
// pquad_pkg
// Widths and shared types for the point-in-quad test pipeline.
// ----------------------------------------------------------------------------
package pquad_pkg;

  // input coordinate width, two's complement
  localparam int unsigned COORD_W = 24;
  // coordinate difference
  localparam int unsigned DIFF_W  = COORD_W + 1;
  // product of two differences
  localparam int unsigned PROD_W  = 2 * DIFF_W;
  // cross product (difference of two products)
  localparam int unsigned CROSS_W = PROD_W + 1;
  // sum of two cross products
  localparam int unsigned SUM_W   = CROSS_W + 1;

  // three-valued sign: negative, zero, positive (neither flag set)
  typedef struct packed {
    logic neg;
    logic zero;
  } sgn_t;

  function automatic sgn_t sign_of(input logic signed [CROSS_W-1:0] val);
    sgn_t s;
    s.neg  = val[CROSS_W-1];
    s.zero = (val == '0);
    return s;
  endfunction

endpackage

[design/point_in_quad_test_unit.sv]
// ----------------------------------------------------------------------------
// point_in_quad_test_unit
// Point-in-quad test: picks triangle q0,q1,q2 or q1,q2,q3 by the side of edge
// q1-q2, then runs an exact barycentric inside test.
// ----------------------------------------------------------------------------
// A new query is taken in every cycle: busy is never raised, so start alone
// launches a transfer. The result appears on inside_res_o with done_o high,
// in order, one per query, and is shown for a single cycle only. The six
// stages are: coordinate differences, 25x25 products, cross products,
// barycentric sum and signs, exact compare, triangle select. Both candidate
// triangles are evaluated in parallel, so the side decision does not
// lengthen the pipeline.
// ----------------------------------------------------------------------------
module point_in_quad_test_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [pquad_pkg::COORD_W-1:0] q0_x_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] q0_y_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] q1_x_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] q1_y_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] q2_x_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] q2_y_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] q3_x_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] q3_y_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pquad_pkg::COORD_W-1:0] point_y_i,
  output logic                                 done_o,
  output logic                                 inside_res_o
);

  localparam int unsigned NSTAGE = 6;

  logic [NSTAGE-1:0] vld_d, vld_q;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // -- stage 1: differences --------------------------------------------------
  // edge q1->q2 (shared with triangle B as e0), p-q1 (shared as e2), q0-q1
  logic signed [pquad_pkg::DIFF_W-1:0] ex_q, ey_q, px1_q, py1_q, cx_q, cy_q;
  // triangle A: e0 = q1-q0, e1 = q2-q0, e2 = p-q0
  logic signed [pquad_pkg::DIFF_W-1:0] a0x_q, a0y_q, a1x_q, a1y_q, a2x_q, a2y_q;
  // triangle B: e1 = q3-q1
  logic signed [pquad_pkg::DIFF_W-1:0] b1x_q, b1y_q;

  function automatic logic signed [pquad_pkg::DIFF_W-1:0] sub_c(
    input logic signed [pquad_pkg::COORD_W-1:0] a,
    input logic signed [pquad_pkg::COORD_W-1:0] b
  );
    return pquad_pkg::DIFF_W'(a) - pquad_pkg::DIFF_W'(b);
  endfunction

  always_ff @(posedge clk_i) begin
    ex_q  <= sub_c(q2_x_i, q1_x_i);
    ey_q  <= sub_c(q2_y_i, q1_y_i);
    px1_q <= sub_c(point_x_i, q1_x_i);
    py1_q <= sub_c(point_y_i, q1_y_i);
    cx_q  <= sub_c(q0_x_i, q1_x_i);
    cy_q  <= sub_c(q0_y_i, q1_y_i);
    a0x_q <= sub_c(q1_x_i, q0_x_i);
    a0y_q <= sub_c(q1_y_i, q0_y_i);
    a1x_q <= sub_c(q2_x_i, q0_x_i);
    a1y_q <= sub_c(q2_y_i, q0_y_i);
    a2x_q <= sub_c(point_x_i, q0_x_i);
    a2y_q <= sub_c(point_y_i, q0_y_i);
    b1x_q <= sub_c(q3_x_i, q1_x_i);
    b1y_q <= sub_c(q3_y_i, q1_y_i);
  end

  // -- stages 2-3: cross products --------------------------------------------
  logic signed [pquad_pkg::CROSS_W-1:0] side_p, side_q0;
  logic signed [pquad_pkg::CROSS_W-1:0] det_a, u_a, v_a, det_b, u_b, v_b;

  pquad_cross u_side_p  (.clk_i, .ax_i(ex_q),  .ay_i(ey_q),  .bx_i(px1_q), .by_i(py1_q),
                         .cross_o(side_p));
  pquad_cross u_side_q0 (.clk_i, .ax_i(ex_q),  .ay_i(ey_q),  .bx_i(cx_q),  .by_i(cy_q),
                         .cross_o(side_q0));
  pquad_cross u_det_a   (.clk_i, .ax_i(a0x_q), .ay_i(a0y_q), .bx_i(a1x_q), .by_i(a1y_q),
                         .cross_o(det_a));
  pquad_cross u_u_a     (.clk_i, .ax_i(a2x_q), .ay_i(a2y_q), .bx_i(a1x_q), .by_i(a1y_q),
                         .cross_o(u_a));
  pquad_cross u_v_a     (.clk_i, .ax_i(a0x_q), .ay_i(a0y_q), .bx_i(a2x_q), .by_i(a2y_q),
                         .cross_o(v_a));
  pquad_cross u_det_b   (.clk_i, .ax_i(ex_q),  .ay_i(ey_q),  .bx_i(b1x_q), .by_i(b1y_q),
                         .cross_o(det_b));
  pquad_cross u_u_b     (.clk_i, .ax_i(px1_q), .ay_i(py1_q), .bx_i(b1x_q), .by_i(b1y_q),
                         .cross_o(u_b));
  pquad_cross u_v_b     (.clk_i, .ax_i(ex_q),  .ay_i(ey_q),  .bx_i(px1_q), .by_i(py1_q),
                         .cross_o(v_b));

  // -- stages 4-5: inside tests for both candidate triangles ------------------
  logic in_a, in_b;

  pquad_tri u_tri_a (.clk_i, .det_i(det_a), .u_i(u_a), .v_i(v_a), .inside_o(in_a));
  pquad_tri u_tri_b (.clk_i, .det_i(det_b), .u_i(u_b), .v_i(v_b), .inside_o(in_b));

  // side decision, aligned with the triangle compare
  logic same_side_d, same_side4_q, same_side5_q;

  assign same_side_d = (pquad_pkg::sign_of(side_p) == pquad_pkg::sign_of(side_q0));

  always_ff @(posedge clk_i) begin
    same_side4_q <= same_side_d;
    same_side5_q <= same_side4_q;
  end

  // -- stage 6: select and output ----------------------------------------------
  logic inside_d, inside_q;

  assign inside_d = vld_q[NSTAGE-2] && (same_side5_q ? in_a : in_b);
  assign vld_d    = {vld_q[NSTAGE-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      inside_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      inside_q <= inside_d;
    end
  end

  assign done_o       = vld_q[NSTAGE-1];
  assign inside_res_o = inside_q;

`ifndef SYNTH
  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("transfer did not produce a result after six cycles");

  a_done_has_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 6))
    else $error("result strobe without a matching transfer");

  a_inside_only_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_res_o |-> done_o)
    else $error("inside flag raised outside a result cycle");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[0]) |-> !busy && $past(start))
    else $error("pipeline entry without a start");
`endif

endmodule

[design/pquad_cross.sv]
// ----------------------------------------------------------------------------
// pquad_cross
// Two-stage 2D cross product: registered products, then registered difference.
// ----------------------------------------------------------------------------
module pquad_cross (
  input  logic                                  clk_i,
  input  logic signed [pquad_pkg::DIFF_W-1:0]   ax_i,
  input  logic signed [pquad_pkg::DIFF_W-1:0]   ay_i,
  input  logic signed [pquad_pkg::DIFF_W-1:0]   bx_i,
  input  logic signed [pquad_pkg::DIFF_W-1:0]   by_i,
  output logic signed [pquad_pkg::CROSS_W-1:0]  cross_o
);

  logic signed [pquad_pkg::PROD_W-1:0]  pa_d, pa_q;
  logic signed [pquad_pkg::PROD_W-1:0]  pb_d, pb_q;
  logic signed [pquad_pkg::CROSS_W-1:0] cross_d, cross_q;

  assign pa_d = ax_i * by_i;
  assign pb_d = ay_i * bx_i;

  assign cross_d = pquad_pkg::CROSS_W'(pa_q) - pquad_pkg::CROSS_W'(pb_q);

  always_ff @(posedge clk_i) begin
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    cross_q <= cross_d;
  end

  assign cross_o = cross_q;

endmodule

[design/pquad_tri.sv]
// ----------------------------------------------------------------------------
// pquad_tri
// Barycentric inside test from D, u and v: sum and signs, then exact compare.
// ----------------------------------------------------------------------------
module pquad_tri (
  input  logic                                  clk_i,
  input  logic signed [pquad_pkg::CROSS_W-1:0]  det_i,
  input  logic signed [pquad_pkg::CROSS_W-1:0]  u_i,
  input  logic signed [pquad_pkg::CROSS_W-1:0]  v_i,
  output logic                                  inside_o
);

  logic signed [pquad_pkg::SUM_W-1:0] sum_d, sum_q;
  logic signed [pquad_pkg::SUM_W-1:0] det_q;
  pquad_pkg::sgn_t                    det_sgn_q, u_sgn_q, v_sgn_q;
  logic                               inside_d, inside_q;
  logic                               pos_ok, neg_ok;

  assign sum_d = pquad_pkg::SUM_W'(u_i) + pquad_pkg::SUM_W'(v_i);

  // D > 0: u >= 0, v >= 0, u+v < D.  D < 0: mirrored.  D == 0: outside.
  assign pos_ok = !u_sgn_q.neg && !v_sgn_q.neg && (sum_q < det_q);
  assign neg_ok = (u_sgn_q.neg || u_sgn_q.zero) && (v_sgn_q.neg || v_sgn_q.zero) &&
                  (det_q < sum_q);

  always_comb begin
    inside_d = 1'b0;
    if (!det_sgn_q.zero) begin
      inside_d = det_sgn_q.neg ? neg_ok : pos_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q     <= sum_d;
    det_q     <= pquad_pkg::SUM_W'(det_i);
    det_sgn_q <= pquad_pkg::sign_of(det_i);
    u_sgn_q   <= pquad_pkg::sign_of(u_i);
    v_sgn_q   <= pquad_pkg::sign_of(v_i);
    inside_q  <= inside_d;
  end

  assign inside_o = inside_q;

endmodule

[tb/point_in_quad_test_unit_test.sv]
// ----------------------------------------------------------------------------
// point_in_quad_test_unit_test
// Self-checking bench for the point-in-quad test. It streams directed and
// random quad/point queries through the start/busy handshake and predicts
// each inside flag with exact 64-bit cross products. Results are checked in
// order as they come out on done_o. Sender idling varies from phase to phase.
// ----------------------------------------------------------------------------
module point_in_quad_test_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [pquad_pkg::COORD_W-1:0] coord_t;
  typedef longint corner_t [4];

  typedef struct {
    coord_t q0_x;
    coord_t q0_y;
    coord_t q1_x;
    coord_t q1_y;
    coord_t q2_x;
    coord_t q2_y;
    coord_t q3_x;
    coord_t q3_y;
    coord_t point_x;
    coord_t point_y;
  } quad_query_t;

  localparam longint CMAX = 2 ** (pquad_pkg::COORD_W - 1) - 1;
  localparam longint CMIN = -(2 ** (pquad_pkg::COORD_W - 1));
  // one unit in fixed point with 8 fractional bits
  localparam longint S    = 256;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start  = 1'b0;
  logic        busy;
  logic        done_o;
  logic        inside_res_o;
  quad_query_t drv_q  = '{default: '0};

  quad_query_t pending_queries[$];
  bit          expected_inside[$];
  int unsigned sender_idle_pct = 0;
  int unsigned err_cnt         = 0;

  point_in_quad_test_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .q0_x_i      (drv_q.q0_x),
    .q0_y_i      (drv_q.q0_y),
    .q1_x_i      (drv_q.q1_x),
    .q1_y_i      (drv_q.q1_y),
    .q2_x_i      (drv_q.q2_x),
    .q2_y_i      (drv_q.q2_y),
    .q3_x_i      (drv_q.q3_x),
    .q3_y_i      (drv_q.q3_y),
    .point_x_i   (drv_q.point_x),
    .point_y_i   (drv_q.point_y),
    .done_o      (done_o),
    .inside_res_o(inside_res_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  function automatic longint cross_z(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  function automatic int sign3(longint v);
    return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
  endfunction

  // exact barycentric test: u >= 0, v >= 0, u + v < 1, all scaled by det
  function automatic bit in_triangle(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy, longint px, longint py);
    longint det, u, v, s;
    det = cross_z(bx - ax, by - ay, cx - ax, cy - ay);
    u   = cross_z(px - ax, py - ay, cx - ax, cy - ay);
    v   = cross_z(bx - ax, by - ay, px - ax, py - ay);
    s   = u + v;
    if (det == 0) return 1'b0;
    if (det > 0) return (u >= 0) && (v >= 0) && (s < det);
    return (u <= 0) && (v <= 0) && (s > det);
  endfunction

  function automatic bit inside_quad(quad_query_t q);
    corner_t vx, vy;
    longint  px, py;
    int      p_side, q0_side;
    vx = '{q.q0_x, q.q1_x, q.q2_x, q.q3_x};
    vy = '{q.q0_y, q.q1_y, q.q2_y, q.q3_y};
    px = q.point_x;
    py = q.point_y;
    // zero is a side of its own
    p_side  = sign3(cross_z(vx[2] - vx[1], vy[2] - vy[1], px - vx[1], py - vy[1]));
    q0_side = sign3(cross_z(vx[2] - vx[1], vy[2] - vy[1], vx[0] - vx[1], vy[0] - vy[1]));
    if (p_side == q0_side)
      return in_triangle(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2], px, py);
    return in_triangle(vx[1], vy[1], vx[2], vy[2], vx[3], vy[3], px, py);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_query(corner_t vx, corner_t vy, longint px, longint py);
    quad_query_t q;
    q.q0_x    = coord_t'(vx[0]);
    q.q0_y    = coord_t'(vy[0]);
    q.q1_x    = coord_t'(vx[1]);
    q.q1_y    = coord_t'(vy[1]);
    q.q2_x    = coord_t'(vx[2]);
    q.q2_y    = coord_t'(vy[2]);
    q.q3_x    = coord_t'(vx[3]);
    q.q3_y    = coord_t'(vy[3]);
    q.point_x = coord_t'(px);
    q.point_y = coord_t'(py);
    pending_queries.push_back(q);
  endtask

  function automatic longint rnd_full();
    coord_t c;
    c = coord_t'($urandom);
    return c;
  endfunction

  function automatic longint near_to(longint c, int unsigned span);
    return c + longint'($urandom_range(2 * span)) - longint'(span);
  endfunction

  function automatic longint pick_extreme();
    case ($urandom_range(4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  task automatic gen_random_query();
    corner_t     vx, vy;
    longint      px, py, cx, cy, dx, dy, t;
    int unsigned span, k, nk;
    span = 1 << $urandom_range(20, 1);
    cx   = near_to(0, 1 << 21);
    cy   = near_to(0, 1 << 21);
    // jittered square around the center, either winding
    for (int i = 0; i < 4; i++) begin
      vx[i] = near_to((i == 1 || i == 2) ? cx + span : cx - span, span / 2);
      vy[i] = near_to((i >= 2) ? cy + span : cy - span, span / 2);
    end
    if ($urandom_range(1)) begin
      t = vx[1]; vx[1] = vx[3]; vx[3] = t;
      t = vy[1]; vy[1] = vy[3]; vy[3] = t;
    end
    px = near_to(cx, span + span / 2);
    py = near_to(cy, span + span / 2);
    k  = $urandom_range(3);
    nk = (k + 1) % 4;
    case ($urandom_range(9))
      0, 1: begin
        for (int i = 0; i < 4; i++) begin
          vx[i] = rnd_full();
          vy[i] = rnd_full();
        end
        px = rnd_full();
        py = rnd_full();
      end
      6: begin
        // point on a corner or exactly on an edge midpoint
        vx[k] &= ~64'sd1; vy[k] &= ~64'sd1; vx[nk] &= ~64'sd1; vy[nk] &= ~64'sd1;
        if ($urandom_range(1)) begin
          px = vx[k];
          py = vy[k];
        end else begin
          px = (vx[k] + vx[nk]) / 2;
          py = (vy[k] + vy[nk]) / 2;
        end
      end
      7: begin
        // collinear corners, zero determinant
        dx = near_to(0, span);
        dy = near_to(0, span);
        vx[1] = vx[0] + dx;
        vy[1] = vy[0] + dy;
        vx[2] = vx[0] + 2 * dx;
        vy[2] = vy[0] + 2 * dy;
        if ($urandom_range(1)) begin
          vx[3] = vx[0] + 3 * dx;
          vy[3] = vy[0] + 3 * dy;
        end
        if ($urandom_range(1)) begin
          px = vx[0] + dx / 2;
          py = vy[0] + dy / 2;
        end
      end
      8: begin
        for (int i = 0; i < 4; i++) begin
          vx[i] = pick_extreme();
          vy[i] = pick_extreme();
        end
        px = pick_extreme();
        py = pick_extreme();
      end
      9: begin
        px = vx[k] + longint'($urandom_range(2)) - 1;
        py = vy[k] + longint'($urandom_range(2)) - 1;
      end
      default: ;
    endcase
    add_query(vx, vy, px, py);
  endtask

  // wait until nothing is queued, on the ports or in flight
  task automatic drain();
    while (pending_queries.size() != 0 || start || expected_inside.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!start || !busy) begin
        if (pending_queries.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          drv_q <= pending_queries.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: records each query transfer, checks each result in order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit exp_inside;
    if (rst_ni) begin
      if (start && !busy)
        expected_inside.push_back(inside_quad(drv_q));
      if (done_o !== 1'b0) begin
        if (expected_inside.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, actual done %b inside_res %b",
                   $time, done_o, inside_res_o);
        end else begin
          exp_inside = expected_inside.pop_front();
          if (done_o !== 1'b1 || inside_res_o !== exp_inside) begin
            err_cnt++;
            $display("%0t: inside_res mismatch, expected %b, actual %b (done %b)",
                     $time, exp_inside, inside_res_o, done_o);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idle_plan[4];
    idle_plan = '{0, 87, 7, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // unit square: inside, outside, corners, edges
    add_query('{0, S, S, 0}, '{0, 0, S, S}, 64, 32);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, 32, 64);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, 128, 128);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, 0, 0);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, S, 0);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, S, 128);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, 300, 300);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, S + 64, 128);
    add_query('{0, S, S, 0}, '{0, 0, S, S}, S - 1, 1);
    // clockwise winding, negative determinant
    add_query('{0, 0, S, S}, '{0, S, S, 0}, 32, 64);
    // degenerate: coincident and collinear corners
    add_query('{0, 0, 0, 0}, '{0, 0, 0, 0}, 0, 0);
    add_query('{0, S, 2 * S, 3 * S}, '{0, S, 2 * S, 3 * S}, 128, 128);
    // full-range quads
    add_query('{CMIN, CMAX, CMAX, CMIN}, '{CMIN, CMIN, CMAX, CMAX}, 0, 0);
    add_query('{CMIN, CMAX, CMAX, CMIN}, '{CMIN, CMIN, CMAX, CMAX}, CMIN, CMAX);
    add_query('{CMIN, CMAX, CMAX, CMIN}, '{CMIN, CMIN, CMAX, CMAX}, CMAX, CMIN);
    add_query('{CMAX, CMIN, CMIN, CMAX}, '{CMAX, CMAX, CMIN, CMIN}, CMIN, CMIN);
    add_query('{CMIN, CMAX, CMAX, CMIN}, '{CMIN, CMIN, CMAX, CMAX}, CMAX, CMAX);
    // concave quad
    add_query('{0, S, 64, 0}, '{0, 0, 64, S}, 32, 32);
    add_query('{-1, -1, -1, -1}, '{-1, -1, -1, -1}, -1, -1);
    add_query('{CMAX, CMAX, CMAX, CMAX}, '{CMAX, CMAX, CMAX, CMAX}, CMAX, CMAX);
    add_query('{CMIN, CMIN, CMIN, CMIN}, '{CMIN, CMIN, CMIN, CMIN}, CMIN, CMIN);
    drain();

    foreach (idle_plan[ph]) begin
      sender_idle_pct = idle_plan[ph];
      repeat (158) gen_random_query();
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS point_in_quad_test_unit");
    end else begin
      $display("FAIL point_in_quad_test_unit");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL point_in_quad_test_unit");
    $finish;
  end

endmodule

[point_in_quad_test_unit.f]
design/pquad_pkg.sv
design/pquad_cross.sv
design/pquad_tri.sv
design/point_in_quad_test_unit.sv
tb/point_in_quad_test_unit_test.sv
